[sv/wps_pkg.sv]
// Shared types and constants for the widest-path search block.
// No dependencies; imported by every module of the block.
`default_nettype none

package wps_pkg;

    localparam int MAX_NODES_DEF   = 1024;
    localparam int MAX_EDGES_DEF   = 4096;
    localparam int WEIGHT_BITS_DEF = 24;

    localparam int ID_W     = 11;   // node id and node count field width
    localparam int WIN_W    = 24;   // weight field width
    localparam int CAP_W    = 27;   // capacity width
    localparam logic [CAP_W-1:0] INF_CAP = CAP_W'(100000000);

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_QUERY = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic store_edge;
        logic clear_graph;
        logic load_n;
        logic clr_step;
        logic init_src;
        logic scan_start;
        logic scan_rd;
        logic settle;
        logic edge_start;
        logic edge_rd;
        logic edge_chk;
        logic node_chk;
        logic res_src;
        logic res_unreach;
        logic res_found;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic n_one;
        logic node_last;
        logic have;
        logic u_last;
        logic edges_done;
    } t_stat;

endpackage

`default_nettype wire

[sv/wps_dp.sv]
// Datapath of the widest-path search: edge store, per-node memory, scan and relax logic.
// Depends on wps_pkg.
`default_nettype none

module wps_dp #(
    parameter int MAX_NODES   = wps_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = wps_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = wps_pkg::WEIGHT_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wps_pkg::t_cmd               i_cmd,
    output wps_pkg::t_stat              o_stat,
    input  wire  [wps_pkg::ID_W-1:0]    i_node_count,
    input  wire  [wps_pkg::ID_W-1:0]    i_node_a,
    input  wire  [wps_pkg::ID_W-1:0]    i_node_b,
    input  wire  [wps_pkg::WIN_W-1:0]   i_weight,
    output logic                        o_done,
    output logic [wps_pkg::CAP_W-1:0]   o_bottleneck,
    output logic                        o_reachable,
    output logic                        o_overflow
);
    import wps_pkg::*;

    localparam int NODE_W = $clog2(MAX_NODES);
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int EIDX_W = $clog2(MAX_EDGES);
    localparam int ECNT_W = $clog2(MAX_EDGES + 1);
    localparam int W_EFF  = (WEIGHT_BITS < WIN_W) ? WEIGHT_BITS : WIN_W;
    localparam int EW     = 2 * NODE_W + W_EFF;
    localparam int NW     = CAP_W + 2;

    logic [EW-1:0] edge_mem [MAX_EDGES];
    logic [NW-1:0] node_mem [MAX_NODES];

    logic [ECNT_W-1:0] r_etotal, n_etotal;
    logic              r_dropped, n_dropped;
    logic [CNT_W-1:0]  r_n;
    logic [NODE_W-1:0] r_nidx;
    logic [ECNT_W-1:0] r_eidx;
    logic [NODE_W-1:0] r_u, r_v, r_scan_id;
    logic [CAP_W-1:0]  r_best_u, r_cand;
    logic              r_have, r_hit, r_scan_vld;
    logic [EW-1:0]     r_erd;
    logic [NW-1:0]     r_nrd;
    logic              r_done, r_reach, r_ovf;
    logic [CAP_W-1:0]  r_bott;

    logic [NODE_W-1:0] last;
    logic              a_ok, b_ok, e_we;
    logic [NODE_W-1:0] e_a, e_b, v_c;
    logic [CAP_W-1:0]  e_cap, cand_c;
    logic              hit_c;
    logic              node_we;
    logic [NODE_W-1:0] node_waddr, node_raddr;
    logic [NW-1:0]     node_wdata;
    logic [CNT_W-1:0]  n_clamp;

    assign last = NODE_W'(r_n - CNT_W'(1));

    // Edge intake
    assign a_ok = (i_node_a != '0) && (32'(i_node_a) <= MAX_NODES);
    assign b_ok = (i_node_b != '0) && (32'(i_node_b) <= MAX_NODES);
    assign e_we = i_cmd.store_edge && a_ok && b_ok && (32'(r_etotal) < MAX_EDGES);

    always_comb begin
        n_etotal  = r_etotal;
        n_dropped = r_dropped;
        if (i_cmd.clear_graph) begin
            n_etotal  = '0;
            n_dropped = 1'b0;
        end else if (i_cmd.store_edge && a_ok && b_ok) begin
            if (e_we) n_etotal = r_etotal + ECNT_W'(1);
            else      n_dropped = 1'b1;
        end
    end

    // Node count clamp
    always_comb begin
        if (i_node_count == '0)                 n_clamp = CNT_W'(1);
        else if (32'(i_node_count) > MAX_NODES) n_clamp = CNT_W'(MAX_NODES);
        else                                    n_clamp = CNT_W'(i_node_count);
    end

    // Edge fields and neighbor select
    assign e_a   = r_erd[EW-1 -: NODE_W];
    assign e_b   = r_erd[W_EFF +: NODE_W];
    assign e_cap = CAP_W'(r_erd[W_EFF-1:0]);
    assign cand_c = (e_cap < r_best_u) ? e_cap : r_best_u;

    always_comb begin
        v_c   = e_b;
        hit_c = 1'b0;
        if (e_a == r_u) begin
            v_c   = e_b;
            hit_c = 1'b1;
        end else if (e_b == r_u) begin
            v_c   = e_a;
            hit_c = 1'b1;
        end
        if (CNT_W'(v_c) >= r_n) hit_c = 1'b0;
    end

    // Node memory port muxing
    always_comb begin
        node_we    = 1'b0;
        node_waddr = r_nidx;
        node_wdata = '0;
        node_raddr = r_nidx;
        if (i_cmd.clr_step) begin
            node_we = 1'b1;
        end else if (i_cmd.init_src) begin
            node_we    = 1'b1;
            node_waddr = '0;
            node_wdata = {1'b1, 1'b0, INF_CAP};
        end else if (i_cmd.settle) begin
            node_we    = 1'b1;
            node_waddr = r_u;
            node_wdata = {1'b1, 1'b1, r_best_u};
        end else if (i_cmd.node_chk) begin
            node_waddr = r_v;
            node_wdata = {1'b1, 1'b0, r_cand};
            node_we    = r_hit && !r_nrd[CAP_W] &&
                         (!r_nrd[CAP_W+1] || (r_cand > r_nrd[CAP_W-1:0]));
        end
        if (i_cmd.edge_chk) node_raddr = v_c;
    end

    always_ff @(posedge i_clk) begin
        if (e_we) edge_mem[r_etotal[EIDX_W-1:0]] <= {NODE_W'(i_node_a - ID_W'(1)),
                                                      NODE_W'(i_node_b - ID_W'(1)),
                                                      i_weight[W_EFF-1:0]};
        if (i_cmd.edge_rd) r_erd <= edge_mem[r_eidx[EIDX_W-1:0]];
        if (node_we) node_mem[node_waddr] <= node_wdata;
        r_nrd <= node_mem[node_raddr];
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_n) r_n <= n_clamp;
        r_scan_id <= r_nidx;
        if (i_cmd.edge_chk) begin
            r_v    <= v_c;
            r_cand <= cand_c;
            r_hit  <= hit_c;
        end
        if (i_cmd.res_src) begin
            r_bott  <= INF_CAP;
            r_reach <= 1'b1;
        end else if (i_cmd.res_unreach) begin
            r_bott  <= '0;
            r_reach <= 1'b0;
        end else if (i_cmd.res_found) begin
            r_bott  <= r_best_u;
            r_reach <= 1'b1;
        end
        if (i_cmd.res_src || i_cmd.res_unreach || i_cmd.res_found) r_ovf <= r_dropped;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_etotal   <= '0;
            r_dropped  <= 1'b0;
            r_nidx     <= '0;
            r_eidx     <= '0;
            r_have     <= 1'b0;
            r_scan_vld <= 1'b0;
            r_done     <= 1'b0;
            r_u        <= '0;
            r_best_u   <= '0;
        end else begin
            r_etotal   <= n_etotal;
            r_dropped  <= n_dropped;
            r_done     <= i_cmd.res_src || i_cmd.res_unreach || i_cmd.res_found;
            r_scan_vld <= i_cmd.scan_rd;
            if (i_cmd.load_n || i_cmd.scan_start)             r_nidx <= '0;
            else if (i_cmd.clr_step || i_cmd.scan_rd)         r_nidx <= r_nidx + NODE_W'(1);
            if (i_cmd.edge_start)    r_eidx <= '0;
            else if (i_cmd.node_chk) r_eidx <= r_eidx + ECNT_W'(1);
            if (i_cmd.scan_start) begin
                r_have <= 1'b0;
            end else if (r_scan_vld && r_nrd[CAP_W+1] && !r_nrd[CAP_W] &&
                         (!r_have || (r_nrd[CAP_W-1:0] > r_best_u))) begin
                r_have   <= 1'b1;
                r_u      <= r_scan_id;
                r_best_u <= r_nrd[CAP_W-1:0];
            end
        end
    end

    assign o_stat.n_one      = (r_n == CNT_W'(1));
    assign o_stat.node_last  = (r_nidx == last);
    assign o_stat.have       = r_have;
    assign o_stat.u_last     = (r_u == last);
    assign o_stat.edges_done = (r_eidx == r_etotal);

    assign o_done       = r_done;
    assign o_bottleneck = r_bott;
    assign o_reachable  = r_reach;
    assign o_overflow   = r_ovf;

endmodule

`default_nettype wire

[sv/wps_ctrl.sv]
// Sequencer of the widest-path search: clear sweep, node scan, settle and edge relax.
// Depends on wps_pkg.
`default_nettype none

module wps_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_start,
    input  wire  [1:0]        i_op,
    input  wps_pkg::t_stat    i_stat,
    output wps_pkg::t_cmd     o_cmd,
    output logic              o_busy
);
    import wps_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CLR, S_INIT, S_SCAN, S_SCAN_END, S_SEL, S_ERD, S_ECHK, S_NCHK
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        OP_ADD:   o_cmd.store_edge = 1'b1;
                        OP_CLEAR: o_cmd.clear_graph = 1'b1;
                        OP_QUERY: begin
                            o_cmd.load_n = 1'b1;
                            n_state      = S_CLR;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.node_last) n_state = S_INIT;
            end
            S_INIT: begin
                if (i_stat.n_one) begin
                    o_cmd.res_src = 1'b1;
                    n_state       = S_IDLE;
                end else begin
                    o_cmd.init_src   = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_stat.node_last) n_state = S_SCAN_END;
            end
            S_SCAN_END: n_state = S_SEL;
            S_SEL: begin
                if (!i_stat.have) begin
                    o_cmd.res_unreach = 1'b1;
                    n_state           = S_IDLE;
                end else begin
                    o_cmd.settle = 1'b1;
                    if (i_stat.u_last) begin
                        o_cmd.res_found = 1'b1;
                        n_state         = S_IDLE;
                    end else begin
                        o_cmd.edge_start = 1'b1;
                        n_state          = S_ERD;
                    end
                end
            end
            S_ERD: begin
                if (i_stat.edges_done) begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = S_SCAN;
                end else begin
                    o_cmd.edge_rd = 1'b1;
                    n_state       = S_ECHK;
                end
            end
            S_ECHK: begin
                o_cmd.edge_chk = 1'b1;
                n_state        = S_NCHK;
            end
            S_NCHK: begin
                o_cmd.node_chk = 1'b1;
                n_state        = S_ERD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

[sv/widest_path_search.sv]
// Top level of the widest-path search: APB register, sequencer and datapath.
// Depends on wps_pkg, wps_ctrl and wps_dp.
`default_nettype none

// Edge loads and clears can be issued back to back; they never produce a result. A
// query (op 2) raises busy and walks the graph from node 1 to node node_count,
// settling one node per round. Each round scans all n nodes of the node memory and
// then relaxes every stored edge in turn (edge memory read, node memory read,
// conditional write). The result appears on o_bottleneck, o_reachable and
// o_overflow, marked by o_done, which is high for a single cycle, the first cycle in
// which busy is low; the receiver cannot stall it, so capture it then. node_count is
// written through the APB port at address 0; the user must do so only while the
// block is idle, as the block itself does not enforce it.
module widest_path_search #(
    parameter int MAX_NODES   = wps_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = wps_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = wps_pkg::WEIGHT_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         start,
    output logic                        busy,
    input  wire  [1:0]                  i_op,
    input  wire  [wps_pkg::ID_W-1:0]    i_node_a,
    input  wire  [wps_pkg::ID_W-1:0]    i_node_b,
    input  wire  [wps_pkg::WIN_W-1:0]   i_weight,
    output logic                        o_done,
    output logic [wps_pkg::CAP_W-1:0]   o_bottleneck,
    output logic                        o_reachable,
    output logic                        o_overflow,
    input  wire                         psel,
    input  wire                         penable,
    input  wire                         pwrite,
    input  wire  [2:0]                  paddr,
    input  wire  [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import wps_pkg::*;

    logic [ID_W-1:0] r_node_count;
    t_cmd            cmd;
    t_stat           stat;
    logic            wr_en;

    // Register 0 is node_count; the upper word address holds nothing.
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-ID_W){1'b0}}, r_node_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= ID_W'(1);
        end else if (wr_en && !paddr[2]) begin
            r_node_count <= pwdata[ID_W-1:0];
        end
    end

    // Sequencer: accepts a transaction only while idle
    wps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // Storage, search state and result registers
    wps_dp #(
        .MAX_NODES   (MAX_NODES),
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_node_count (r_node_count),
        .i_node_a     (i_node_a),
        .i_node_b     (i_node_b),
        .i_weight     (i_weight),
        .o_done       (o_done),
        .o_bottleneck (o_bottleneck),
        .o_reachable  (o_reachable),
        .o_overflow   (o_overflow)
    );

endmodule

`default_nettype wire

[sv/wps_checker.sv]
// Port-level checks for the widest-path search, bound to the top level.
// Depends on wps_pkg and widest_path_search.
`default_nettype none

module wps_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         start,
    input wire                         busy,
    input wire  [1:0]                  i_op,
    input wire                         o_done,
    input wire  [wps_pkg::CAP_W-1:0]   o_bottleneck,
    input wire                         o_reachable,
    input wire                         pready
);
    import wps_pkg::*;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result while busy");

    a_unreach_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_reachable) |-> (o_bottleneck == '0))
        else $error("unreachable result with nonzero capacity");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_op == OP_QUERY)) |=> (busy && !o_done))
        else $error("query did not raise busy");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready) else $error("pready low");

endmodule

bind widest_path_search wps_checker u_wps_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_op         (i_op),
    .o_done       (o_done),
    .o_bottleneck (o_bottleneck),
    .o_reachable  (o_reachable),
    .pready       (pready)
);

`default_nettype wire
